// ===== src/tcw_pkg.sv =====
// shared types and constants of the text console writer
package tcw_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  typedef logic [10:0] pos_t;
  typedef logic [4:0]  row_t;
  typedef logic [6:0]  col_t;
  typedef logic [15:0] cell_t;
  typedef logic [7:0]  char_t;
  typedef logic [10:0] addr_t;

  localparam cell_t RESET_CELL = {ATTR_RESET, BLANK_CODE};

  typedef enum logic [1:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e   op;
    char_t char_code;
    addr_t read_address;
    logic  addr_ok;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_status_t;

endpackage

// ===== src/tcw_ram.sv =====
// generic single-write, single-read memory with registered read data
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tcw_front.sv =====
// front end: takes requests, classifies them and queues commands for the back end
module tcw_front #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  input  tcw_pkg::char_t        char_code_i,
  input  tcw_pkg::addr_t        read_address_i,
  output logic                  q_valid_o,
  output tcw_pkg::cmd_t         cmd_o,
  input  tcw_pkg::back_status_t back_i
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int QD    = tcw_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(QD);
  localparam int CNT_W = $clog2(QD + 1);

  tcw_pkg::cmd_t    q_mem [QD];
  tcw_pkg::cmd_t    cmd_in;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             full;
  logic             push;

  // classify
  always_comb begin
    cmd_in.char_code    = char_code_i;
    cmd_in.read_address = read_address_i;
    cmd_in.addr_ok      = 32'(read_address_i) < CELLS;
    if (kind_i) begin
      cmd_in.op = tcw_pkg::OP_READ;
    end else if (char_code_i == tcw_pkg::NEWLINE_CODE) begin
      cmd_in.op = tcw_pkg::OP_NEWLINE;
    end else begin
      cmd_in.op = tcw_pkg::OP_PUT;
    end
  end

  assign full       = count_q == CNT_W'(QD);
  assign in_stall_o = full || back_i.clearing;
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = count_q != '0;
  assign cmd_o      = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (back_i.pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !back_i.pop) begin
      count_d = count_q + 1'b1;
    end else if (!push && back_i.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_i.pop |-> q_valid_o)
    else $error("command popped from empty queue");

endmodule

// ===== src/tcw_back.sv =====
// back end: cursor, screen store sequencing (clear, write, read, scroll) and result register
module tcw_back #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  input  tcw_pkg::cmd_t                      cmd_i,
  output tcw_pkg::back_status_t              status_o,
  input  tcw_pkg::char_t                     attr_i,
  output logic                               ram_we_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]    ram_waddr_o,
  output tcw_pkg::cell_t                     ram_wdata_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]    ram_raddr_o,
  input  tcw_pkg::cell_t                     ram_rdata_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tcw_pkg::pos_t                      cursor_position_o,
  output tcw_pkg::row_t                      cursor_row_out_o,
  output tcw_pkg::col_t                      cursor_column_out_o,
  output logic                               scrolled_o,
  output tcw_pkg::cell_t                     cell_data_o
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [PW-1:0] LAST_BASE = PW'((ROWS - 1) * COLUMNS);
  localparam logic [PW-1:0] COL_STEP  = PW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] MOVE_LAST = AW'(CELLS - COLUMNS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_MOVE  = 3'd3;
  localparam logic [2:0] ST_BLANK = 3'd4;

  logic [2:0]     state_q, state_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [RW-1:0]  row_q, row_d;
  logic [CW-1:0]  col_q, col_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic           read_ok_q, read_ok_d;
  logic           out_valid_q;
  tcw_pkg::pos_t  res_pos_q;
  tcw_pkg::row_t  res_row_q;
  tcw_pkg::col_t  res_col_q;
  logic           res_scr_q;
  tcw_pkg::cell_t res_cell_q;

  logic           slot_free;
  logic           pop;
  logic           res_load;
  logic [PW-1:0]  res_pos;
  logic [RW-1:0]  res_row;
  logic [CW-1:0]  res_col;
  logic           res_scr;
  tcw_pkg::cell_t res_cell;

  logic           wrap;
  logic           at_last_row;
  logic           need_scroll;
  logic [RW-1:0]  nx_row;
  logic [CW-1:0]  nx_col;
  logic [PW-1:0]  nx_pos;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign wrap        = col_q == LAST_COL;
  assign at_last_row = row_q == LAST_ROW;

  // cursor after a put or newline, before any scroll
  always_comb begin
    if (cmd_i.op == tcw_pkg::OP_NEWLINE) begin
      nx_row      = row_q + 1'b1;
      nx_col      = '0;
      nx_pos      = pos_q - PW'(col_q) + COL_STEP;
      need_scroll = at_last_row;
    end else begin
      nx_row      = wrap ? row_q + 1'b1 : row_q;
      nx_col      = wrap ? '0 : col_q + 1'b1;
      nx_pos      = pos_q + 1'b1;
      need_scroll = wrap && at_last_row;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    row_d       = row_q;
    col_d       = col_q;
    pos_d       = pos_q;
    read_ok_d   = read_ok_q;
    pop         = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = {attr_i, tcw_pkg::BLANK_CODE};
    ram_raddr_o = '0;
    res_load    = 1'b0;
    res_pos     = pos_q;
    res_row     = row_q;
    res_col     = col_q;
    res_scr     = 1'b0;
    res_cell    = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = tcw_pkg::RESET_CELL;
        if (idx_q == LAST_CELL) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid_i && slot_free) begin
          pop = 1'b1;
          case (cmd_i.op)
            tcw_pkg::OP_READ: begin
              ram_raddr_o = AW'(cmd_i.read_address);
              read_ok_d   = cmd_i.addr_ok;
              state_d     = ST_READ;
            end
            tcw_pkg::OP_PUT, tcw_pkg::OP_NEWLINE: begin
              if (cmd_i.op == tcw_pkg::OP_PUT) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = AW'(pos_q);
                ram_wdata_o = {attr_i, cmd_i.char_code};
              end
              if (need_scroll) begin
                row_d       = LAST_ROW;
                col_d       = '0;
                pos_d       = LAST_BASE;
                idx_d       = '0;
                ram_raddr_o = AW'(COLUMNS);
                state_d     = ST_MOVE;
              end else begin
                row_d    = nx_row;
                col_d    = nx_col;
                pos_d    = nx_pos;
                res_load = 1'b1;
                res_row  = nx_row;
                res_col  = nx_col;
                res_pos  = nx_pos;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        res_load = 1'b1;
        res_cell = read_ok_q ? ram_rdata_i : '0;
        state_d  = ST_IDLE;
      end
      ST_MOVE: begin
        // cell idx takes the one a row below it
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i;
        idx_d       = idx_q + 1'b1;
        if (idx_q == MOVE_LAST) begin
          state_d = ST_BLANK;
        end else begin
          ram_raddr_o = AW'(32'(idx_q) + COLUMNS + 1);
        end
      end
      ST_BLANK: begin
        ram_we_o = 1'b1;
        if (idx_q == LAST_CELL) begin
          idx_d    = '0;
          res_load = 1'b1;
          res_scr  = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      pos_q       <= '0;
      read_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      row_q     <= row_d;
      col_q     <= col_d;
      pos_q     <= pos_d;
      read_ok_q <= read_ok_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_pos_q  <= tcw_pkg::pos_t'(res_pos);
      res_row_q  <= tcw_pkg::row_t'(res_row);
      res_col_q  <= tcw_pkg::col_t'(res_col);
      res_scr_q  <= res_scr;
      res_cell_q <= res_cell;
    end
  end

  assign status_o.pop      = pop;
  assign status_o.clearing = state_q == ST_CLEAR;

  assign out_valid_o         = out_valid_q;
  assign cursor_position_o   = res_pos_q;
  assign cursor_row_out_o    = res_row_q;
  assign cursor_column_out_o = res_col_q;
  assign scrolled_o          = res_scr_q;
  assign cell_data_o         = res_cell_q;

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> slot_free)
    else $error("result loaded over a held result");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < ROWS && 32'(col_q) < COLUMNS)
    else $error("cursor outside the screen");

  a_pos_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) == 32'(row_q) * COLUMNS + 32'(col_q))
    else $error("linear cursor position out of step with row and column");

  a_no_pop_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.clearing |-> !status_o.pop)
    else $error("command taken during clearing pass");

endmodule

// ===== src/text_console_writer.sv =====
// top level of the text console writer: attribute register, front end, back end, screen store
// a put result is registered as the back end takes its command, a read result in ST_READ
// throughput: one put per cycle unless results stall, a scroll runs or a read waits in ST_READ
// a put or newline that scrolls walks the store one cell per cycle: ST_MOVE, then ST_BLANK
// reset: a clearing pass writes the blank reset cell to every cell, requests stall meanwhile
// the attribute register is written at any cycle and takes effect on later cell writes
module text_console_writer #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  tcw_pkg::char_t text_attribute_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           kind_i,
  input  tcw_pkg::char_t char_code_i,
  input  tcw_pkg::addr_t read_address_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tcw_pkg::pos_t  cursor_position_o,
  output tcw_pkg::row_t  cursor_row_out_o,
  output tcw_pkg::col_t  cursor_column_out_o,
  output logic           scrolled_o,
  output tcw_pkg::cell_t cell_data_o
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  tcw_pkg::char_t        attr_q;
  logic                  q_valid;
  tcw_pkg::cmd_t         cmd;
  tcw_pkg::back_status_t status;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  tcw_pkg::cell_t        ram_wdata;
  tcw_pkg::cell_t        ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::ATTR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      attr_q <= text_attribute_i;
    end
  end

  tcw_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .char_code_i    (char_code_i),
    .read_address_i (read_address_i),
    .q_valid_o      (q_valid),
    .cmd_o          (cmd),
    .back_i         (status)
  );

  tcw_ram #(
    .WIDTH ($bits(tcw_pkg::cell_t)),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tcw_back #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .cmd_i               (cmd),
    .status_o            (status),
    .attr_i              (attr_q),
    .ram_we_o            (ram_we),
    .ram_waddr_o         (ram_waddr),
    .ram_wdata_o         (ram_wdata),
    .ram_raddr_o         (ram_raddr),
    .ram_rdata_i         (ram_rdata),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .cursor_position_o   (cursor_position_o),
    .cursor_row_out_o    (cursor_row_out_o),
    .cursor_column_out_o (cursor_column_out_o),
    .scrolled_o          (scrolled_o),
    .cell_data_o         (cell_data_o)
  );

endmodule

// ===== tb/text_console_checker.sv =====
`timescale 1ns / 1ps
// request kinds and the checker that predicts and compares every console report

package console_tb_pkg;

  typedef enum logic {
    KIND_PUT  = 1'b0,
    KIND_READ = 1'b1
  } item_kind_e;

endpackage

module text_console_checker #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  tcw_pkg::char_t text_attribute_i,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  logic           kind_i,
  input  tcw_pkg::char_t char_code_i,
  input  tcw_pkg::addr_t read_address_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  tcw_pkg::pos_t  cursor_position_i,
  input  tcw_pkg::row_t  cursor_row_out_i,
  input  tcw_pkg::col_t  cursor_column_out_i,
  input  logic           scrolled_i,
  input  tcw_pkg::cell_t cell_data_i,
  output int             mismatch_count_o,
  output int             pending_count_o
);

  localparam int CELLS = ROWS * COLUMNS;

  typedef struct packed {
    tcw_pkg::pos_t  pos;
    tcw_pkg::row_t  row;
    tcw_pkg::col_t  col;
    logic           scrolled;
    tcw_pkg::cell_t cell_data;
  } console_report_t;

  tcw_pkg::cell_t  screen [CELLS];
  int              cur_row;
  int              cur_col;
  tcw_pkg::char_t  attribute;
  console_report_t report_q [$];
  int              mismatches = 0;

  initial begin
    mismatch_count_o = 0;
    pending_count_o  = 0;
  end

  function automatic tcw_pkg::cell_t compose(input tcw_pkg::char_t code);
    return {attribute, code};
  endfunction

  task automatic clear_console();
    attribute = tcw_pkg::ATTR_RESET;
    cur_row   = 0;
    cur_col   = 0;
    foreach (screen[i]) screen[i] = {tcw_pkg::ATTR_RESET, tcw_pkg::BLANK_CODE};
    report_q.delete();
  endtask

  // apply one request to the shadow screen and queue its report
  task automatic advance_console(input logic kind, input tcw_pkg::char_t code,
                                 input tcw_pkg::addr_t addr);
    console_report_t rep;
    int idx;
    rep = '0;
    if (kind == console_tb_pkg::KIND_READ) begin
      if (addr < CELLS) rep.cell_data = screen[addr];
    end else begin
      if (code == tcw_pkg::NEWLINE_CODE) begin
        cur_col = 0;
        cur_row++;
      end else begin
        idx = cur_row * COLUMNS + cur_col;
        if (idx < CELLS) screen[idx] = compose(code);
        cur_col++;
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
      end
      if (cur_row >= ROWS) begin
        for (int i = 0; i + COLUMNS < CELLS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
          screen[i] = compose(tcw_pkg::BLANK_CODE);
        end
        cur_row      = ROWS - 1;
        rep.scrolled = 1'b1;
      end
    end
    rep.pos = tcw_pkg::pos_t'(cur_row * COLUMNS + cur_col);
    rep.row = tcw_pkg::row_t'(cur_row);
    rep.col = tcw_pkg::col_t'(cur_col);
    report_q.push_back(rep);
  endtask

  function automatic void check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s: expected %0d, actual %0d", name, expected, actual);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    console_report_t want;
    if (!rst_ni) begin
      clear_console();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (report_q.size() == 0) begin
          $error("report with no request pending");
          mismatches++;
        end else begin
          want = report_q.pop_front();
          check_field("cursor_position", want.pos, cursor_position_i);
          check_field("cursor_row_out", want.row, cursor_row_out_i);
          check_field("cursor_column_out", want.col, cursor_column_out_i);
          check_field("scrolled", want.scrolled, scrolled_i);
          check_field("cell_data", want.cell_data, cell_data_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) attribute = text_attribute_i;
      if (in_valid_i && !in_stall_i) advance_console(kind_i, char_code_i, read_address_i);
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= report_q.size();
  end

endmodule

// ===== tb/text_console_writer_tb.sv =====
`timescale 1ns / 1ps
// testbench top: request stimulus, report stalls and verdict for the text console writer
module text_console_writer_tb;

  localparam int ROWS         = 25;
  localparam int COLUMNS      = 80;
  localparam int CELLS        = ROWS * COLUMNS;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 250;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 400;

  logic           clk;
  logic           rst_n     = 1'b0;
  logic           cfg_valid = 1'b0;
  tcw_pkg::char_t attr_in   = tcw_pkg::ATTR_RESET;
  logic           in_valid  = 1'b0;
  logic           kind_in   = console_tb_pkg::KIND_PUT;
  tcw_pkg::char_t char_in   = '0;
  tcw_pkg::addr_t addr_in   = '0;
  logic           out_stall = 1'b1;

  logic           cfg_ready;
  logic           in_stall;
  logic           out_valid;
  tcw_pkg::pos_t  cursor_position;
  tcw_pkg::row_t  report_row;
  tcw_pkg::col_t  cursor_column;
  logic           scrolled;
  tcw_pkg::cell_t cell_data;

  int mismatches;
  int pending;
  int sent  = 0;
  int taken = 0;

  text_console_writer #(
    .ROWS   (ROWS),
    .COLUMNS(COLUMNS)
  ) dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .text_attribute_i   (attr_in),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .kind_i             (kind_in),
    .char_code_i        (char_in),
    .read_address_i     (addr_in),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .cursor_position_o  (cursor_position),
    .cursor_row_out_o   (report_row),
    .cursor_column_out_o(cursor_column),
    .scrolled_o         (scrolled),
    .cell_data_o        (cell_data)
  );

  text_console_checker #(
    .ROWS   (ROWS),
    .COLUMNS(COLUMNS)
  ) console_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .text_attribute_i   (attr_in),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .kind_i             (kind_in),
    .char_code_i        (char_in),
    .read_address_i     (addr_in),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .cursor_position_i  (cursor_position),
    .cursor_row_out_i   (report_row),
    .cursor_column_out_i(cursor_column),
    .scrolled_i         (scrolled),
    .cell_data_i        (cell_data),
    .mismatch_count_o   (mismatches),
    .pending_count_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #(150_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // report side: random stall per report, one long hold-off to back up the block
  initial begin
    int hold;
    forever begin
      if (taken == HOLD_AT) hold = HOLD_CYCLES;
      else if (taken % 150 < 30) hold = 0;
      else hold = $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  task automatic offer(input console_tb_pkg::item_kind_e kind, input tcw_pkg::char_t code,
                       input tcw_pkg::addr_t addr);
    int gap;
    gap = (sent % 200 < 40) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind_in  <= kind;
    char_in  <= code;
    addr_in  <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic offer_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      offer(console_tb_pkg::KIND_READ, tcw_pkg::char_t'($urandom),
            tcw_pkg::addr_t'($urandom_range(0, CELLS - 1)));
    end else if (pick < 25) begin
      offer(console_tb_pkg::KIND_READ, tcw_pkg::char_t'($urandom),
            tcw_pkg::addr_t'($urandom_range(CELLS, 2047)));
    end else if (pick < 32) begin
      offer(console_tb_pkg::KIND_PUT, tcw_pkg::NEWLINE_CODE, tcw_pkg::addr_t'($urandom));
    end else begin
      offer(console_tb_pkg::KIND_PUT, tcw_pkg::char_t'($urandom), tcw_pkg::addr_t'($urandom));
    end
  endtask

  // stop offering requests, wait until every report is in, then idle for the given pause
  task automatic settle(input int pause);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (pause) @(posedge clk);
  endtask

  task automatic write_attribute(input tcw_pkg::char_t value);
    cfg_valid <= 1'b1;
    attr_in   <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    tcw_pkg::char_t attr;
    wait (rst_n === 1'b1);
    @(posedge clk);

    offer(console_tb_pkg::KIND_READ, 8'h00, '0);
    offer(console_tb_pkg::KIND_READ, 8'hFF, tcw_pkg::addr_t'(CELLS - 1));
    offer(console_tb_pkg::KIND_READ, 8'h00, tcw_pkg::addr_t'(CELLS));
    offer(console_tb_pkg::KIND_READ, 8'h00, '1);
    offer(console_tb_pkg::KIND_PUT, 8'h00, '0);
    offer(console_tb_pkg::KIND_PUT, 8'hFF, '1);
    offer(console_tb_pkg::KIND_PUT, 8'h80, '0);
    offer(console_tb_pkg::KIND_PUT, 8'h7F, '0);
    offer(console_tb_pkg::KIND_PUT, tcw_pkg::NEWLINE_CODE, '0);
    offer(console_tb_pkg::KIND_PUT, tcw_pkg::BLANK_CODE, '0);
    offer(console_tb_pkg::KIND_PUT, tcw_pkg::NEWLINE_CODE, '0);
    offer(console_tb_pkg::KIND_PUT, tcw_pkg::NEWLINE_CODE, '0);
    for (int i = 0; i < 5; i++) offer(console_tb_pkg::KIND_READ, 8'h00, tcw_pkg::addr_t'(i));
    offer(console_tb_pkg::KIND_READ, 8'h00, tcw_pkg::addr_t'(COLUMNS));
    offer(console_tb_pkg::KIND_READ, 8'h00, tcw_pkg::addr_t'(COLUMNS + 1));

    for (int phase = 0; phase < PHASES; phase++) begin
      settle(CELLS + 16);
      attr = (phase == 0) ? 8'hFF : (phase == 1) ? 8'h00 : tcw_pkg::char_t'($urandom);
      write_attribute(attr);
      repeat (PHASE_ITEMS) offer_random();
    end

    settle(16);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
